FILE: rtl/hrms_pkg.sv
// Shared types and action codes for the history ring with match search.
package hrms_pkg;

  localparam logic [1:0] ACT_PUSH   = 2'd0;
  localparam logic [1:0] ACT_FLUSH  = 2'd1;
  localparam logic [1:0] ACT_LOCATE = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] element;
  } hrms_in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] slot_index;
  } hrms_out_t;

  typedef struct packed {
    logic active;
    logic found;
  } hrms_token_t;

endpackage

FILE: rtl/hrms_cell.sv
// One history slot with its comparator and one stage of the search token chain.
module hrms_cell #(
  parameter int ELEMENT_BITS = 64,
  parameter int IDX_W        = 4,
  parameter int CELL_INDEX   = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [IDX_W-1:0]        wr_pos_i,
  input  logic                    wrapped_i,
  input  logic [ELEMENT_BITS-1:0] wr_data_i,
  input  logic [ELEMENT_BITS-1:0] key_i,
  input  hrms_pkg::hrms_token_t   tok_i,
  input  logic [IDX_W-1:0]        idx_i,
  output hrms_pkg::hrms_token_t   tok_o,
  output logic [IDX_W-1:0]        idx_o
);

  localparam logic [IDX_W-1:0] MyIndex = IDX_W'(CELL_INDEX);

  logic [ELEMENT_BITS-1:0] slot_q;
  hrms_pkg::hrms_token_t   tok_q, tok_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    slot_valid;
  logic                    hit;

  assign slot_valid = wrapped_i || (MyIndex < wr_pos_i);
  assign hit        = tok_i.active && slot_valid && (slot_q == key_i);

  always_comb begin
    tok_d.active = tok_i.active;
    tok_d.found  = tok_i.found || hit;
    if (tok_i.found) begin
      idx_d = idx_i;
    end else if (hit) begin
      idx_d = MyIndex;
    end else begin
      idx_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_pos_i == MyIndex)) begin
      slot_q <= wr_data_i;
    end
    idx_q <= idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

FILE: rtl/history_ring_with_match_search_core.sv
// Top level of the history ring with a cell chain that searches for matching elements.
//
//   Channel  Direction  Payload               Handshake
//   in       input      hrms_pkg::hrms_in_t   in_valid_i / in_stall_o
//   out      output     hrms_pkg::hrms_out_t  out_valid_o / out_stall_i
//
// A push or flush transaction is done when it is accepted, and the next may follow at once.
// A locate transaction walks a token through the DEPTH cells, one cell a cycle,
// so its result is registered on the output after the last cell; input stalls meanwhile.
// A new locate also stalls while an earlier result still waits on the output.
// Reset clears the write position, the wrap mark and the chain; slots keep no reset.
module history_ring_with_match_search_core #(
  parameter int DEPTH        = 16,
  parameter int ELEMENT_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hrms_pkg::hrms_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hrms_pkg::hrms_out_t  out_data_o
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [IDX_W-1:0] LastPos = IDX_W'(DEPTH - 1);

  logic                    accept;
  logic                    do_push;
  logic                    do_flush;
  logic                    do_locate;
  logic [ELEMENT_BITS-1:0] elem;

  logic [IDX_W-1:0]        wr_pos_q, wr_pos_d;
  logic                    wrapped_q, wrapped_d;
  logic                    busy_q, busy_d;
  logic                    start_q;
  logic [ELEMENT_BITS-1:0] key_q;
  logic                    out_valid_q, out_valid_d;
  hrms_pkg::hrms_out_t     out_data_q;

  hrms_pkg::hrms_token_t   tok [DEPTH+1];
  logic [IDX_W-1:0]        idx [DEPTH+1];
  logic [IDX_W+3:0]        idx_ext;

  assign in_stall_o = busy_q ||
                      (out_valid_q && (in_data_i.action == hrms_pkg::ACT_LOCATE));
  assign accept     = in_valid_i && !in_stall_o;
  assign do_push    = accept && (in_data_i.action == hrms_pkg::ACT_PUSH);
  assign do_flush   = accept && (in_data_i.action == hrms_pkg::ACT_FLUSH);
  assign do_locate  = accept && (in_data_i.action == hrms_pkg::ACT_LOCATE);
  assign elem       = in_data_i.element[ELEMENT_BITS-1:0];

  always_comb begin
    wr_pos_d  = wr_pos_q;
    wrapped_d = wrapped_q;
    if (do_flush) begin
      wr_pos_d  = '0;
      wrapped_d = 1'b0;
    end else if (do_push) begin
      if (wr_pos_q == LastPos) begin
        wr_pos_d  = '0;
        wrapped_d = 1'b1;
      end else begin
        wr_pos_d = wr_pos_q + 1'b1;
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (do_locate) begin
      busy_d = 1'b1;
    end else if (tok[DEPTH].active) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (tok[DEPTH].active) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q    <= '0;
      wrapped_q   <= 1'b0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      wr_pos_q    <= wr_pos_d;
      wrapped_q   <= wrapped_d;
      busy_q      <= busy_d;
      start_q     <= do_locate;
      out_valid_q <= out_valid_d;
    end
  end

  assign idx_ext = {4'b0000, idx[DEPTH]};

  always_ff @(posedge clk_i) begin
    if (do_locate) begin
      key_q <= elem;
    end
    if (tok[DEPTH].active) begin
      out_data_q.found      <= tok[DEPTH].found;
      out_data_q.slot_index <= idx_ext[3:0];
    end
  end

  assign tok[0].active = start_q;
  assign tok[0].found  = 1'b0;
  assign idx[0]        = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    hrms_cell #(
      .ELEMENT_BITS (ELEMENT_BITS),
      .IDX_W        (IDX_W),
      .CELL_INDEX   (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (do_push),
      .wr_pos_i  (wr_pos_q),
      .wrapped_i (wrapped_q),
      .wr_data_i (elem),
      .key_i     (key_q),
      .tok_i     (tok[g]),
      .idx_i     (idx[g]),
      .tok_o     (tok[g+1]),
      .idx_o     (idx[g+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/hrms_checker.sv
// Port-level assertions for the history ring core and the bind that attaches them.
module hrms_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input hrms_pkg::hrms_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input hrms_pkg::hrms_out_t out_data_o
);

  // A stalled result transaction holds its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An accepted locate keeps the input stalled while its search runs.
  a_locate_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.action == hrms_pkg::ACT_LOCATE)
    |=> in_stall_o)
    else $error("input not stalled after locate");

  // A result only appears at the end of a search, while the input was stalled.
  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a running search");

  // A miss reports slot index zero.
  a_miss_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.slot_index == 4'd0)
    else $error("miss with nonzero slot index");

endmodule

bind history_ring_with_match_search_core hrms_checker u_hrms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
